// ===== src/tar_pkg.sv =====
// shared constants and types for the triangle aspect ratio pipeline
// no dependencies; used by tar_front, tar_div_step and triangle_aspect_ratio
package tar_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int RATIO_BITS     = 32;
  localparam int FRONT_STAGES   = 5;

  typedef struct packed {
    logic sat;
    logic degen;
  } tar_flags_t;

endpackage

// ===== src/tar_front.sv =====
// front pipeline: edge vectors, squares and cross product, longest edge,
// |cross| and divider setup in five register stages; depends on tar_pkg
module tar_front #(
  parameter int COORD_BITS = tar_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = tar_pkg::FRAC_BITS_DEF,
  localparam int LEN_W     = 2 * COORD_BITS + 1
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            up_valid,
  output logic                            up_ready,
  input  logic signed [COORD_BITS-1:0]    ax,
  input  logic signed [COORD_BITS-1:0]    ay,
  input  logic signed [COORD_BITS-1:0]    bx,
  input  logic signed [COORD_BITS-1:0]    by_coord,
  input  logic signed [COORD_BITS-1:0]    cx,
  input  logic signed [COORD_BITS-1:0]    cy,
  output logic                            dn_valid,
  input  logic                            dn_ready,
  output logic [LEN_W-1:0]                d,
  output logic [LEN_W-1:0]                rem,
  output logic [tar_pkg::RATIO_BITS-1:0]  nq,
  output tar_pkg::tar_flags_t             flags
);

  localparam int DIF_W = COORD_BITS + 1;
  localparam int SQ_W  = 2 * COORD_BITS;
  localparam int CR_W  = 2 * DIF_W;
  localparam int NUM_W = LEN_W + tar_pkg::RATIO_BITS;
  localparam int NS    = tar_pkg::FRONT_STAGES;

  logic [NS-1:0] v_r;
  logic [NS-1:0] rdy;
  logic [NS-1:0] v_in;

  // stage 1: edge vectors
  logic signed [DIF_W-1:0] dx_ab_r, dy_ab_r, dx_ac_r, dy_ac_r, dx_bc_r, dy_bc_r;
  // stage 2: squares and cross terms
  logic [SQ_W-1:0]         sx_ab_r, sy_ab_r, sx_ac_r, sy_ac_r, sx_bc_r, sy_bc_r;
  logic signed [CR_W-1:0]  p1_r, p2_r;
  logic signed [CR_W-1:0]  p1_full, p2_full;
  logic signed [CR_W-1:0]  q_ab_x, q_ab_y, q_ac_x, q_ac_y, q_bc_x, q_bc_y;
  // stage 3: squared lengths and cross product
  logic [LEN_W-1:0]        l_ab_r, l_ac_r, l_bc_r;
  logic signed [CR_W-1:0]  cr_r;
  // stage 4: longest edge and |cross|
  logic [LEN_W-1:0]        lmax_r, d4_r;
  logic [LEN_W-1:0]        lmax_nxt;
  logic signed [CR_W-1:0]  cr_abs;
  // stage 5: divider setup
  logic [LEN_W-1:0]        d_r, rem_r;
  logic [tar_pkg::RATIO_BITS-1:0] nq_r;
  tar_pkg::tar_flags_t     flags_r;
  logic [NUM_W-1:0]        num;
  logic [LEN_W-1:0]        rem_nxt;

  // a stage moves when it is empty or the next one moves
  always_comb begin
    rdy[NS-1] = !v_r[NS-1] || dn_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign v_in = {v_r[NS-2:0], up_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_in[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && v_in[0]) begin
      dx_ab_r <= DIF_W'(bx) - DIF_W'(ax);
      dy_ab_r <= DIF_W'(by_coord) - DIF_W'(ay);
      dx_ac_r <= DIF_W'(cx) - DIF_W'(ax);
      dy_ac_r <= DIF_W'(cy) - DIF_W'(ay);
      dx_bc_r <= DIF_W'(cx) - DIF_W'(bx);
      dy_bc_r <= DIF_W'(cy) - DIF_W'(by_coord);
    end
  end

  always_comb begin
    q_ab_x  = CR_W'(dx_ab_r) * CR_W'(dx_ab_r);
    q_ab_y  = CR_W'(dy_ab_r) * CR_W'(dy_ab_r);
    q_ac_x  = CR_W'(dx_ac_r) * CR_W'(dx_ac_r);
    q_ac_y  = CR_W'(dy_ac_r) * CR_W'(dy_ac_r);
    q_bc_x  = CR_W'(dx_bc_r) * CR_W'(dx_bc_r);
    q_bc_y  = CR_W'(dy_bc_r) * CR_W'(dy_bc_r);
    p1_full = CR_W'(dx_ab_r) * CR_W'(dy_ac_r);
    p2_full = CR_W'(dy_ab_r) * CR_W'(dx_ac_r);
  end

  // squares of a difference stay below 2^(2*COORD_BITS)
  always_ff @(posedge clk) begin
    if (rdy[1] && v_in[1]) begin
      sx_ab_r <= q_ab_x[SQ_W-1:0];
      sy_ab_r <= q_ab_y[SQ_W-1:0];
      sx_ac_r <= q_ac_x[SQ_W-1:0];
      sy_ac_r <= q_ac_y[SQ_W-1:0];
      sx_bc_r <= q_bc_x[SQ_W-1:0];
      sy_bc_r <= q_bc_y[SQ_W-1:0];
      p1_r    <= p1_full;
      p2_r    <= p2_full;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[2] && v_in[2]) begin
      l_ab_r <= LEN_W'(sx_ab_r) + LEN_W'(sy_ab_r);
      l_ac_r <= LEN_W'(sx_ac_r) + LEN_W'(sy_ac_r);
      l_bc_r <= LEN_W'(sx_bc_r) + LEN_W'(sy_bc_r);
      cr_r   <= p1_r - p2_r;
    end
  end

  always_comb begin
    lmax_nxt = l_ab_r;
    if (l_ac_r > lmax_nxt) begin
      lmax_nxt = l_ac_r;
    end
    if (l_bc_r > lmax_nxt) begin
      lmax_nxt = l_bc_r;
    end
    cr_abs = cr_r[CR_W-1] ? -cr_r : cr_r;
  end

  // |cross| stays below 2^(2*COORD_BITS+1)
  always_ff @(posedge clk) begin
    if (rdy[3] && v_in[3]) begin
      lmax_r <= lmax_nxt;
      d4_r   <= cr_abs[LEN_W-1:0];
    end
  end

  // the upper part of lmax << FRAC_BITS is the first partial remainder;
  // when it already reaches d the quotient needs more than the output width
  always_comb begin
    num     = NUM_W'(lmax_r) << FRAC_BITS;
    rem_nxt = num[NUM_W-1:tar_pkg::RATIO_BITS];
  end

  always_ff @(posedge clk) begin
    if (rdy[4] && v_in[4]) begin
      d_r           <= d4_r;
      rem_r         <= rem_nxt;
      nq_r          <= num[tar_pkg::RATIO_BITS-1:0];
      flags_r.sat   <= (rem_nxt >= d4_r);
      flags_r.degen <= (d4_r == '0);
    end
  end

  assign up_ready = rdy[0];
  assign dn_valid = v_r[NS-1];
  assign d        = d_r;
  assign rem      = rem_r;
  assign nq       = nq_r;
  assign flags    = flags_r;

endmodule

// ===== src/tar_div_step.sv =====
// one registered restoring-division step: one quotient bit per stage
// depends on tar_pkg
module tar_div_step #(
  parameter int LEN_W = 2 * tar_pkg::COORD_BITS_DEF + 1
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            up_valid,
  output logic                            up_ready,
  input  logic [LEN_W-1:0]                d_in,
  input  logic [LEN_W-1:0]                rem_in,
  input  logic [tar_pkg::RATIO_BITS-1:0]  nq_in,
  input  tar_pkg::tar_flags_t             flags_in,
  output logic                            dn_valid,
  input  logic                            dn_ready,
  output logic [LEN_W-1:0]                d_out,
  output logic [LEN_W-1:0]                rem_out,
  output logic [tar_pkg::RATIO_BITS-1:0]  nq_out,
  output tar_pkg::tar_flags_t             flags_out
);

  localparam int QW = tar_pkg::RATIO_BITS;

  logic                v_r;
  logic [LEN_W-1:0]    d_r, rem_r;
  logic [QW-1:0]       nq_r;
  tar_pkg::tar_flags_t flags_r;

  logic [LEN_W:0]      trial;
  logic [LEN_W:0]      diff;
  logic                ge;

  // nq shifts numerator bits out at the top and quotient bits in at the bottom
  always_comb begin
    trial = {rem_in, nq_in[QW-1]};
    diff  = trial - {1'b0, d_in};
    ge    = (trial >= {1'b0, d_in});
  end

  assign up_ready = !v_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      d_r     <= d_in;
      rem_r   <= ge ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
      nq_r    <= {nq_in[QW-2:0], ge};
      flags_r <= flags_in;
    end
  end

  assign dn_valid  = v_r;
  assign d_out     = d_r;
  assign rem_out   = rem_r;
  assign nq_out    = nq_r;
  assign flags_out = flags_r;

endmodule

// ===== src/triangle_aspect_ratio.sv =====
// top level: triangle aspect ratio, longest squared edge over |cross|, 16.16
// depends on tar_pkg, tar_front and tar_div_step
//
//  channel | direction | tdata                                  | tuser
//  --------+-----------+----------------------------------------+------------
//  in_     | slave     | ax, ay, bx, by_coord, cx, cy (low up)  | -
//  out_    | master    | ratio                                  | degenerate
//
// one item per cycle while out_tready does not stall the output; the path runs
// through 5 front stages, 32 divider stages and 1 output register, one bit per divider stage.
// each stage holds its own valid bit and moves when it is empty or the next
// one moves, so bubbles close up behind a stalled output
// synchronous active-low reset clears the valid bits only
module triangle_aspect_ratio #(
  parameter int COORD_BITS = tar_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = tar_pkg::FRAC_BITS_DEF,
  localparam int IN_W      = ((6 * COORD_BITS + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [IN_W-1:0]                 in_tdata,   // ax, ay, bx, by_coord, cx, cy
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [tar_pkg::RATIO_BITS-1:0]  out_tdata,  // ratio
  output logic [0:0]                      out_tuser   // degenerate
);

  localparam int LEN_W = 2 * COORD_BITS + 1;
  localparam int NQ    = tar_pkg::RATIO_BITS;

  logic [NQ:0]             sv;
  logic [NQ:0]             sr;
  logic [LEN_W-1:0]        sd    [NQ];
  logic [LEN_W-1:0]        srem  [NQ];
  logic [NQ-1:0]           snq   [NQ+1];
  tar_pkg::tar_flags_t     sflags[NQ+1];

  logic                    out_tvalid_r;
  logic [NQ-1:0]           ratio_r;
  logic                    degen_r;

  tar_front #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .ax       ($signed(in_tdata[0*COORD_BITS +: COORD_BITS])),
    .ay       ($signed(in_tdata[1*COORD_BITS +: COORD_BITS])),
    .bx       ($signed(in_tdata[2*COORD_BITS +: COORD_BITS])),
    .by_coord ($signed(in_tdata[3*COORD_BITS +: COORD_BITS])),
    .cx       ($signed(in_tdata[4*COORD_BITS +: COORD_BITS])),
    .cy       ($signed(in_tdata[5*COORD_BITS +: COORD_BITS])),
    .dn_valid (sv[0]),
    .dn_ready (sr[0]),
    .d        (sd[0]),
    .rem      (srem[0]),
    .nq       (snq[0]),
    .flags    (sflags[0])
  );

  for (genvar k = 0; k < NQ; k++) begin : g_div
    if (k < NQ - 1) begin : g_mid
      tar_div_step #(
        .LEN_W (LEN_W)
      ) u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (sv[k]),
        .up_ready  (sr[k]),
        .d_in      (sd[k]),
        .rem_in    (srem[k]),
        .nq_in     (snq[k]),
        .flags_in  (sflags[k]),
        .dn_valid  (sv[k+1]),
        .dn_ready  (sr[k+1]),
        .d_out     (sd[k+1]),
        .rem_out   (srem[k+1]),
        .nq_out    (snq[k+1]),
        .flags_out (sflags[k+1])
      );
    end else begin : g_last
      // divisor and remainder are not needed after the last quotient bit
      tar_div_step #(
        .LEN_W (LEN_W)
      ) u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (sv[k]),
        .up_ready  (sr[k]),
        .d_in      (sd[k]),
        .rem_in    (srem[k]),
        .nq_in     (snq[k]),
        .flags_in  (sflags[k]),
        .dn_valid  (sv[k+1]),
        .dn_ready  (sr[k+1]),
        .d_out     (),
        .rem_out   (),
        .nq_out    (snq[k+1]),
        .flags_out (sflags[k+1])
      );
    end
  end

  // output register; saturated and zero-area items read as all ones
  assign sr[NQ] = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (sr[NQ]) begin
      out_tvalid_r <= sv[NQ];
    end
  end

  always_ff @(posedge clk) begin
    if (sr[NQ] && sv[NQ]) begin
      ratio_r <= (sflags[NQ].sat || sflags[NQ].degen) ? '1 : snq[NQ];
      degen_r <= sflags[NQ].degen;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = ratio_r;
  assign out_tuser  = degen_r;

endmodule
